[src/rfbp_pkg.sv]
// Shared types and constants of the reader frame byte parser.
`default_nettype none

package rfbp_pkg;

    // Parser stages, in frame order.
    typedef enum logic [3:0] {
        STG_PREFIX0  = 4'd0,
        STG_PREFIX1  = 4'd1,
        STG_PREFIX2  = 4'd2,
        STG_HEAD     = 4'd3,
        STG_GROUP    = 4'd4,
        STG_CODE     = 4'd5,
        STG_LEN_MARK = 4'd6,
        STG_LENGTH   = 4'd7,
        STG_DATA     = 4'd8,
        STG_PAYLOAD  = 4'd9,
        STG_SUM_MARK = 4'd10,
        STG_CHECKSUM = 4'd11
    } stage_t;

    // Result kinds carried on the output tuser.
    typedef enum logic [1:0] {
        EV_BUSY    = 2'd0,
        EV_PAYLOAD = 2'd1,
        EV_DONE    = 2'd2,
        EV_ERROR   = 2'd3
    } event_t;

    // Frame markers.
    localparam logic [7:0] MARK_HEAD = 8'h01;
    localparam logic [7:0] MARK_LEN  = 8'h02;
    localparam logic [7:0] MARK_DATA = 8'h03;
    localparam logic [7:0] MARK_SUM  = 8'h04;

    // Prefix characters.
    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_E = 8'h45;
    localparam logic [7:0] CHAR_F = 8'h46;
    localparam logic [7:0] CHAR_R = 8'h52;

    // Widths of the result word.
    localparam int unsigned DATA_W = 40;
    localparam int unsigned USER_W = 2;

    // Expected prefix byte at a prefix position; the third is the same for both.
    function automatic logic [7:0] prefix_byte(input logic sel, input stage_t pos);
        logic [7:0] val;
        val = CHAR_E;
        if (pos == STG_PREFIX0) begin
            val = sel ? CHAR_R : CHAR_A;
        end else if (pos == STG_PREFIX1) begin
            val = sel ? CHAR_F : CHAR_A;
        end
        return val;
    endfunction

endpackage

`default_nettype wire

[src/reader_frame_byte_parser.sv]
// Top level of the reader frame byte parser: frame state walk and result register.
//
//   Channel  Direction  Handshake          Contents
//   s_       in         s_tvalid/s_tready  one received byte per word
//   m_       out        m_tvalid/m_tready  one result word per input byte
//   cfg_     in         cfg_we             prefix select bit
//
// Each byte is parsed in the cycle it is accepted and its result is in the
// output register in the following cycle; one byte per cycle is sustained while m_tready is high.
// The input is ready whenever the output register is empty or being taken,
// so a stall on the output side holds the input after one word.
// Reset (aresetn low at a clock edge) returns the parser to prefix hunting
// and empties the output register and clears the prefix select bit.
`default_nettype none

module reader_frame_byte_parser
    import rfbp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,

    // Configuration: prefix select.
    input  wire logic              cfg_we,
    input  wire logic              cfg_wdata,

    // Input stream.
    input  wire logic              s_tvalid,
    output      logic              s_tready,
    input  wire logic [7:0]        s_tdata,   // [7:0] rx_byte

    // Result stream.
    output      logic              m_tvalid,
    input  wire logic              m_tready,
    output      logic [DATA_W-1:0] m_tdata,   // [7:0] byte_out, [15:8] cmd_group,
                                              // [23:16] cmd_code, [31:24] frame_length,
                                              // [35:32] error_stage, [39:36] zero
    output      logic [USER_W-1:0] m_tuser    // [1:0] event_res
);

    // Parser and configuration state.
    logic        prefix_sel_reg;
    stage_t      stage_reg,  stage_next;
    logic [7:0]  group_reg,  group_next;
    logic [7:0]  code_reg,   code_next;
    logic [7:0]  len_reg,    len_next;
    logic [7:0]  count_reg,  count_next;

    // Result register.
    logic        valid_reg;
    event_t      evt_reg,    evt_next;
    logic [7:0]  bout_reg,   bout_next;
    logic [7:0]  grp_reg,    grp_next;
    logic [7:0]  cod_reg,    cod_next;
    logic [7:0]  flen_reg,   flen_next;
    logic [3:0]  est_reg,    est_next;

    stage_t      stage_eff;
    logic [7:0]  count_inc;
    logic        bad;
    logic        s_hs;

    assign s_tready = !valid_reg || m_tready;
    assign s_hs     = s_tvalid && s_tready;

    // Stage codes past the checksum act as the first prefix stage.
    assign stage_eff = (stage_reg > STG_CHECKSUM) ? STG_PREFIX0 : stage_reg;
    assign count_inc = count_reg + 8'd1;

    // Next parser state and result for the byte on the input.
    always_comb begin
        stage_next = stage_reg;
        group_next = group_reg;
        code_next  = code_reg;
        len_next   = len_reg;
        count_next = count_reg;
        evt_next   = EV_BUSY;
        bout_next  = 8'd0;
        grp_next   = 8'd0;
        cod_next   = 8'd0;
        flen_next  = 8'd0;
        est_next   = 4'd0;
        bad        = 1'b0;

        unique case (stage_eff)
            STG_PREFIX0, STG_PREFIX1, STG_PREFIX2: begin
                if (s_tdata == prefix_byte(prefix_sel_reg, stage_eff)) begin
                    stage_next = stage_t'(stage_eff + 4'd1);
                end else begin
                    bad = 1'b1;
                end
            end
            STG_HEAD: begin
                if (s_tdata == MARK_HEAD) begin
                    group_next = 8'd0;
                    code_next  = 8'd0;
                    len_next   = 8'd0;
                    count_next = 8'd0;
                    stage_next = STG_GROUP;
                end else begin
                    bad = 1'b1;
                end
            end
            STG_GROUP: begin
                group_next = s_tdata;
                stage_next = STG_CODE;
            end
            STG_CODE: begin
                code_next  = s_tdata;
                stage_next = STG_LEN_MARK;
            end
            STG_LEN_MARK: begin
                if (s_tdata == MARK_LEN) begin
                    stage_next = STG_LENGTH;
                end else begin
                    bad = 1'b1;
                end
            end
            STG_LENGTH: begin
                len_next   = s_tdata;
                stage_next = (s_tdata == 8'd0) ? STG_SUM_MARK : STG_DATA;
            end
            STG_DATA: begin
                if (s_tdata == MARK_DATA) begin
                    stage_next = STG_PAYLOAD;
                end else begin
                    bad = 1'b1;
                end
            end
            STG_PAYLOAD: begin
                count_next = count_inc;
                evt_next   = EV_PAYLOAD;
                bout_next  = s_tdata;
                flen_next  = len_reg;
                if (count_inc >= len_reg) begin
                    stage_next = STG_SUM_MARK;
                end
            end
            STG_SUM_MARK: begin
                if (s_tdata == MARK_SUM) begin
                    stage_next = STG_CHECKSUM;
                end else begin
                    bad = 1'b1;
                end
            end
            STG_CHECKSUM: begin
                evt_next   = EV_DONE;
                bout_next  = s_tdata;
                grp_next   = group_reg;
                cod_next   = code_reg;
                flen_next  = len_reg;
                stage_next = STG_PREFIX0;
            end
            default: begin
                stage_next = STG_PREFIX0;
            end
        endcase

        // A framing error drops back to prefix hunting.
        if (bad) begin
            evt_next   = EV_ERROR;
            est_next   = stage_eff;
            stage_next = STG_PREFIX0;
        end
    end

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_sel_reg <= 1'b0;
        end else if (cfg_we) begin
            prefix_sel_reg <= cfg_wdata;
        end
    end

    // Parser state advances on each accepted word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= STG_PREFIX0;
            group_reg <= 8'd0;
            code_reg  <= 8'd0;
            len_reg   <= 8'd0;
            count_reg <= 8'd0;
        end else if (s_hs) begin
            stage_reg <= stage_next;
            group_reg <= group_next;
            code_reg  <= code_next;
            len_reg   <= len_next;
            count_reg <= count_next;
        end
    end

    // Output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_hs) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    // Output payload loads with each accepted word.
    always_ff @(posedge aclk) begin
        if (s_hs) begin
            evt_reg  <= evt_next;
            bout_reg <= bout_next;
            grp_reg  <= grp_next;
            cod_reg  <= cod_next;
            flen_reg <= flen_next;
            est_reg  <= est_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = evt_reg;
    assign m_tdata  = {4'd0, est_reg, flen_reg, cod_reg, grp_reg, bout_reg};

`ifndef SYNTHESIS
    // A completed frame returns the parser to prefix hunting.
    a_done_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_hs && evt_next == EV_DONE) |=> (stage_reg == STG_PREFIX0))
        else $error("parser did not restart after a complete frame");

    // A framing error returns the parser to prefix hunting.
    a_error_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_hs && evt_next == EV_ERROR) |=> (stage_reg == STG_PREFIX0))
        else $error("parser did not restart after a framing error");

    // While streaming payload, fewer bytes have been seen than announced.
    a_payload_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_reg == STG_PAYLOAD) |-> (count_reg < len_reg))
        else $error("payload count reached the announced length in payload stage");

    // A payload result always carries a nonzero announced length.
    a_payload_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && evt_reg == EV_PAYLOAD) |-> (flen_reg != 8'd0))
        else $error("payload byte reported for a zero-length frame");
`endif

endmodule

`default_nettype wire

[verif/reader_frame_byte_parser_tb.sv]
// Self-checking testbench for the reader frame byte parser: directed and random byte streams.
module reader_frame_byte_parser_tb
    import rfbp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LONG_HOLD = 250;
    localparam int unsigned LIMIT_NS  = 1_000_000;

    // One predicted result word.
    typedef struct {
        event_t     ev;
        logic [7:0] byte_out;
        logic [7:0] cmd_group;
        logic [7:0] cmd_code;
        logic [7:0] frame_len;
        logic [3:0] err_stage;
    } parse_result_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_we    = 1'b0;
    logic              cfg_wdata = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata   = 8'h00;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic [USER_W-1:0] m_tuser;

    // Parser state as the testbench predicts it.
    logic       alt_prefix;
    stage_t     stage;
    logic [7:0] held_group;
    logic [7:0] held_code;
    logic [7:0] held_len;
    logic [7:0] payload_seen;

    logic [7:0]    rx_bytes[$];
    parse_result_t due_results[$];
    int unsigned   error_count = 0;
    bit            in_taken    = 1'b0;
    bit            quiet       = 1'b0;
    bit            hold_req    = 1'b0;
    int unsigned   hold_left   = 0;
    int unsigned   stall_left  = 0;
    int unsigned   gap_left    = 0;

    reader_frame_byte_parser dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #1 aclk = ~aclk;

    // Advance the predicted parser by one byte and return the word it should produce.
    function automatic parse_result_t parse_byte(input logic [7:0] b);
        parse_result_t r;
        stage_t        cur;
        logic          bad;
        r.ev        = EV_BUSY;
        r.byte_out  = 8'h00;
        r.cmd_group = 8'h00;
        r.cmd_code  = 8'h00;
        r.frame_len = 8'h00;
        r.err_stage = 4'h0;
        cur = stage;
        bad = 1'b0;
        case (cur)
            STG_PREFIX0: begin
                if (b == (alt_prefix ? CHAR_R : CHAR_A)) stage = STG_PREFIX1;
                else bad = 1'b1;
            end
            STG_PREFIX1: begin
                if (b == (alt_prefix ? CHAR_F : CHAR_A)) stage = STG_PREFIX2;
                else bad = 1'b1;
            end
            STG_PREFIX2: begin
                if (b == CHAR_E) stage = STG_HEAD;
                else bad = 1'b1;
            end
            STG_HEAD: begin
                if (b == MARK_HEAD) begin
                    held_group   = 8'h00;
                    held_code    = 8'h00;
                    held_len     = 8'h00;
                    payload_seen = 8'h00;
                    stage        = STG_GROUP;
                end else begin
                    bad = 1'b1;
                end
            end
            STG_GROUP: begin
                held_group = b;
                stage      = STG_CODE;
            end
            STG_CODE: begin
                held_code = b;
                stage     = STG_LEN_MARK;
            end
            STG_LEN_MARK: begin
                if (b == MARK_LEN) stage = STG_LENGTH;
                else bad = 1'b1;
            end
            STG_LENGTH: begin
                held_len = b;
                stage    = (b == 8'h00) ? STG_SUM_MARK : STG_DATA;
            end
            STG_DATA: begin
                if (b == MARK_DATA) stage = STG_PAYLOAD;
                else bad = 1'b1;
            end
            STG_PAYLOAD: begin
                payload_seen = payload_seen + 8'd1;
                r.ev         = EV_PAYLOAD;
                r.byte_out   = b;
                r.frame_len  = held_len;
                if (payload_seen >= held_len) stage = STG_SUM_MARK;
            end
            STG_SUM_MARK: begin
                if (b == MARK_SUM) stage = STG_CHECKSUM;
                else bad = 1'b1;
            end
            default: begin
                r.ev        = EV_DONE;
                r.byte_out  = b;
                r.cmd_group = held_group;
                r.cmd_code  = held_code;
                r.frame_len = held_len;
                stage       = STG_PREFIX0;
            end
        endcase
        // A bad marker or prefix byte drops back to hunting without a second look at it.
        if (bad) begin
            r.ev        = EV_ERROR;
            r.err_stage = cur;
            stage       = STG_PREFIX0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Sender gap before the next word: mostly none, sometimes short, rarely long.
    function automatic int unsigned next_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Queue one frame; a chosen position may be spoiled and leading bytes may be skipped.
    task automatic push_frame(input logic sel, input logic [7:0] grp, input logic [7:0] cod,
                              input logic [7:0] len, input logic [7:0] sum,
                              input int bad_at, input int skip);
        logic [7:0] fq[$];
        fq = '{sel ? CHAR_R : CHAR_A, sel ? CHAR_F : CHAR_A, CHAR_E, MARK_HEAD,
               grp, cod, MARK_LEN, len};
        if (len != 8'h00) begin
            fq.push_back(MARK_DATA);
            repeat (len) fq.push_back(8'($urandom_range(0, 255)));
        end
        fq.push_back(MARK_SUM);
        fq.push_back(sum);
        foreach (fq[i]) begin
            if (i >= skip)
                rx_bytes.push_back(i == bad_at ? fq[i] ^ 8'($urandom_range(1, 255)) : fq[i]);
        end
    endtask

    // Random traffic: mostly good frames, then foreign prefixes, spoiled frames and noise.
    task automatic queue_traffic(input int unsigned n_bytes);
        int unsigned start;
        int unsigned r;
        int unsigned len;
        int          bad_at;
        start = rx_bytes.size();
        while (rx_bytes.size() - start < n_bytes) begin
            r   = $urandom_range(0, 99);
            len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6) : $urandom_range(7, 20);
            if (r < 62) begin
                push_frame(alt_prefix, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'(len), 8'($urandom_range(0, 255)), -1, 0);
            end else if (r < 70) begin
                push_frame(!alt_prefix, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'(len), 8'($urandom_range(0, 255)), -1, 0);
            end else if (r < 87) begin
                case ($urandom_range(0, 5))
                    0: bad_at = 0;
                    1: bad_at = 1;
                    2: bad_at = 2;
                    3: bad_at = 3;
                    4: bad_at = 6;
                    default: bad_at = (len != 0 && $urandom_range(0, 1) == 1) ? 8
                                    : ((len != 0) ? 9 + len : 8);
                endcase
                push_frame(alt_prefix, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'(len), 8'($urandom_range(0, 255)), bad_at, 0);
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    case ($urandom_range(0, 5))
                        0: rx_bytes.push_back(CHAR_A);
                        1: rx_bytes.push_back(CHAR_E);
                        2: rx_bytes.push_back(alt_prefix ? CHAR_R : CHAR_F);
                        3: rx_bytes.push_back(8'($urandom_range(MARK_HEAD, MARK_SUM)));
                        default: rx_bytes.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
            end
        end
    endtask

    // Wait until every queued byte has been taken and its word checked.
    task automatic drain();
        while (rx_bytes.size() != 0 || s_tvalid || due_results.size() != 0 || hold_left != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_prefix_select(input logic sel);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= sel;
        @(posedge aclk);
        alt_prefix = sel;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Check the result channel, then predict for the input channel.
    always @(posedge aclk) begin : watch_channels
        parse_result_t want;
        in_taken = 1'b0;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    report_mismatch("result word with no byte pending", m_tuser, 0);
                end else begin
                    want = due_results.pop_front();
                    if (m_tuser != want.ev)
                        report_mismatch("event_res", m_tuser, want.ev);
                    if (m_tdata[7:0] != want.byte_out)
                        report_mismatch("byte_out", m_tdata[7:0], want.byte_out);
                    if (m_tdata[15:8] != want.cmd_group)
                        report_mismatch("cmd_group", m_tdata[15:8], want.cmd_group);
                    if (m_tdata[23:16] != want.cmd_code)
                        report_mismatch("cmd_code", m_tdata[23:16], want.cmd_code);
                    if (m_tdata[31:24] != want.frame_len)
                        report_mismatch("frame_length", m_tdata[31:24], want.frame_len);
                    if (m_tdata[35:32] != want.err_stage)
                        report_mismatch("error_stage", m_tdata[35:32], want.err_stage);
                end
            end
            if (s_tvalid && s_tready) begin
                due_results.push_back(parse_byte(s_tdata));
                in_taken = 1'b1;
            end
        end
    end

    // Byte sender: holds a word until taken, then waits out a random gap.
    always @(negedge aclk) begin : send_bytes
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (gap_left != 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (rx_bytes.size() != 0) begin
                s_tdata  <= rx_bytes.pop_front();
                s_tvalid <= 1'b1;
                gap_left = next_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus one long hold-off on request.
    always @(negedge aclk) begin : take_results
        int unsigned r;
        if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req  = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (quiet) begin
            m_tready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                m_tready <= 1'b1;
            end else if (r < 95) begin
                stall_left = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                stall_left = $urandom_range(10, 40);
                m_tready <= 1'b0;
            end
        end
    end

    initial begin : run_test
        alt_prefix   = 1'b0;
        stage        = STG_PREFIX0;
        held_group   = 8'h00;
        held_code    = 8'h00;
        held_len     = 8'h00;
        payload_seen = 8'h00;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: a stray byte, a zero-length frame, a one-byte frame, then a lone
        // first prefix byte so that the next setting applies mid-prefix.
        write_prefix_select(1'b0);
        rx_bytes.push_back(8'h00);
        push_frame(1'b0, 8'h00, 8'hFF, 8'h00, 8'hFF, -1, 0);
        push_frame(1'b0, 8'hFF, 8'h00, 8'h01, 8'h00, -1, 0);
        rx_bytes.push_back(CHAR_A);
        drain();

        // Alternate prefix; the frame resumes at its second prefix byte.
        write_prefix_select(1'b1);
        push_frame(1'b1, 8'h5A, 8'hA5, 8'h02, 8'h80, -1, 1);
        queue_traffic(40);
        drain();

        // Default prefix with a long receiver hold-off while bytes keep coming.
        write_prefix_select(1'b0);
        queue_traffic(40);
        hold_req = 1'b1;
        drain();

        // Alternate prefix: a stretch with no idling, then the longest frame and more traffic.
        write_prefix_select(1'b1);
        quiet = 1'b1;
        queue_traffic(15);
        drain();
        quiet = 1'b0;
        push_frame(1'b1, 8'h81, 8'h7E, 8'hFF, 8'h55, -1, 0);
        queue_traffic(15);
        drain();

        if (error_count == 0) begin
            $display("reader_frame_byte_parser test passed");
        end else begin
            $display("reader_frame_byte_parser test failed");
        end
        $finish;
    end

    // Give up if the run hangs.
    initial begin : watchdog
        #(LIMIT_NS);
        $display("reader_frame_byte_parser test failed");
        $finish;
    end

endmodule
